// ===== hdl/priority_grid_next_cell_unit_macros.svh =====
// Assertion macros for the priority grid next-cell unit.
// Included by the modules that carry concurrent checks; no dependencies.
`ifndef PRIORITY_GRID_NEXT_CELL_UNIT_MACROS_SVH
`define PRIORITY_GRID_NEXT_CELL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PGNC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pgnc check failed");
`define PGNC_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pgnc check failed");
`else
`define PGNC_ASSERT_IMP(name, clk, rst, ante, cons)
`define PGNC_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/pgnc_pkg.sv =====
// Shared types and constants for the priority grid next-cell unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package pgnc_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int CELL_W       = 8;
  localparam int TOTAL_W      = 21;
  localparam int SUM_OUT_W    = 20;
  localparam int POS_W        = 6;
  localparam int DIFF_W       = 10;
  localparam int SQ_W         = 16;
  localparam int DIST_W       = 17;
  localparam int SLOT_W       = 4;
  localparam int DRONE_W      = 5;
  localparam int MAX_DRONES   = 16;
  localparam int GRID_W       = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_PRIORITY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DRONES    = 2'd3;

  localparam logic [GRID_W-1:0]  RST_GRID_ROWS     = 7'd5;
  localparam logic [GRID_W-1:0]  RST_GRID_COLS     = 7'd5;
  localparam logic [CELL_W-1:0]  RST_FILL_PRIORITY = 8'd1;
  localparam logic [DRONE_W-1:0] RST_NUM_DRONES    = 5'd1;

  localparam logic FUNC_FILL   = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  typedef struct packed {
    logic             func;
    logic [POS_W-1:0] pos_row;
    logic [POS_W-1:0] pos_col;
  } pgnc_req_t;

  typedef struct packed {
    logic [POS_W-1:0]     sel_row;
    logic [POS_W-1:0]     sel_col;
    logic [CELL_W-1:0]    sel_priority;
    logic [SUM_OUT_W-1:0] remaining_sum;
    logic [SLOT_W-1:0]    drone_slot;
    logic                 done_res;
  } pgnc_rsp_t;

  typedef struct packed {
    logic [GRID_W-1:0]  grid_rows;
    logic [GRID_W-1:0]  grid_cols;
    logic [CELL_W-1:0]  fill_priority;
    logic [DRONE_W-1:0] drones;
  } pgnc_cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_SCAN,
    ST_DRAIN,
    ST_TAKE,
    ST_MOD,
    ST_DONE
  } pgnc_state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_FILL,
    ACC_TAKE
  } pgnc_acc_op_t;

  typedef struct packed {
    logic         rd;
    logic         first;
    logic         wr;
    logic         wr_best;
    logic         wr_fill;
    pgnc_acc_op_t acc_op;
  } pgnc_scan_ctl_t;

endpackage

// ===== hdl/pgnc_scan.sv =====
// Cell memory, distance/priority compare unit and running total.
// Depends on pgnc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "priority_grid_next_cell_unit_macros.svh"
module pgnc_scan import pgnc_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  pgnc_scan_ctl_t                               ctl,
  input  logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] addr,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] row,
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col,
  input  logic [POS_W-1:0]                             pos_row,
  input  logic [POS_W-1:0]                             pos_col,
  input  logic [CELL_W-1:0]                            fill_prio,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] best_row,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] best_col,
  output logic [CELL_W-1:0]                            best_prio,
  output logic [TOTAL_W-1:0]                           total
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [CELL_W-1:0] cell_mem [DEPTH];
  logic [CELL_W-1:0] rd_data;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;

  logic signed [DIFF_W-1:0]   diff_row;
  logic signed [DIFF_W-1:0]   diff_col;
  logic signed [2*DIFF_W-1:0] prod_row;
  logic signed [2*DIFF_W-1:0] prod_col;

  logic              p1_valid;
  logic              p1_first;
  logic [RW-1:0]     p1_row;
  logic [CW-1:0]     p1_col;
  logic [AW-1:0]     p1_addr;
  logic [SQ_W-1:0]   sq_row;
  logic [SQ_W-1:0]   sq_col;

  logic [DIST_W-1:0] dist_cur;
  logic [DIST_W-1:0] best_dist;
  logic [AW-1:0]     best_addr;
  logic              take;
  logic [TOTAL_W-1:0] total_next;

  assign wr_addr = ctl.wr_best ? best_addr : addr;
  assign wr_data = ctl.wr_fill ? fill_prio : '0;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      cell_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= cell_mem[addr];
    end
  end

  // stage 1: squares of the offsets, aligned with the memory read
  assign diff_row = $signed(DIFF_W'(row)) - $signed(DIFF_W'(pos_row));
  assign diff_col = $signed(DIFF_W'(col)) - $signed(DIFF_W'(pos_col));
  assign prod_row = diff_row * diff_row;
  assign prod_col = diff_col * diff_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= ctl.rd;
    end
  end

  always_ff @(posedge clk) begin
    p1_first <= ctl.first;
    p1_row   <= row;
    p1_col   <= col;
    p1_addr  <= addr;
    sq_row   <= SQ_W'(prod_row);
    sq_col   <= SQ_W'(prod_col);
  end

  // stage 2: compare against the best so far
  assign dist_cur = DIST_W'(sq_row) + DIST_W'(sq_col);
  assign take = p1_valid && (p1_first || (rd_data > best_prio) ||
                ((rd_data == best_prio) && (dist_cur < best_dist)));

  always_ff @(posedge clk) begin
    if (take) begin
      best_prio <= rd_data;
      best_dist <= dist_cur;
      best_row  <= p1_row;
      best_col  <= p1_col;
      best_addr <= p1_addr;
    end
  end

  always_comb begin
    total_next = total;
    case (ctl.acc_op)
      ACC_CLEAR: total_next = '0;
      ACC_FILL:  total_next = total + TOTAL_W'(fill_prio);
      ACC_TAKE:  total_next = total - TOTAL_W'(best_prio);
      ACC_HOLD: begin
        if (p1_valid) begin
          total_next = total + TOTAL_W'(rd_data);
        end
      end
      default:   total_next = total;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else begin
      total <= total_next;
    end
  end

  `PGNC_ASSERT_NXT(a_best_monotonic, clk, rst, p1_valid && !p1_first, best_prio >= $past(best_prio))

endmodule

// ===== hdl/pgnc_ctrl.sv =====
// Sequencer: clearing pass, fill and scan address walk, drone slot, result register.
// Depends on pgnc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "priority_grid_next_cell_unit_macros.svh"
module pgnc_ctrl import pgnc_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  pgnc_cfg_t                                    cfg,
  input  logic                                         req_valid,
  output logic                                         req_stall,
  input  pgnc_req_t                                    req_data,
  output logic                                         rsp_valid,
  input  logic                                         rsp_stall,
  output pgnc_rsp_t                                    rsp_data,
  output pgnc_scan_ctl_t                               ctl,
  output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] addr,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] row,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col,
  output logic [POS_W-1:0]                             pos_row,
  output logic [POS_W-1:0]                             pos_col,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] best_row,
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] best_col,
  input  logic [CELL_W-1:0]                            best_prio,
  input  logic [TOTAL_W-1:0]                           total
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LIM_W = 9;

  pgnc_state_t state, state_next;
  logic [RW-1:0]     row_next, last_row, last_row_next, row_adv, cfg_last_row;
  logic [CW-1:0]     col_next, last_col, last_col_next, col_adv, cfg_last_col;
  logic [AW-1:0]     addr_next, addr_adv;
  logic              func, func_next;
  logic [POS_W-1:0]  pos_row_next, pos_col_next;
  logic [SLOT_W-1:0] slot, slot_next, turn, turn_next;
  logic              rsp_valid_next;
  pgnc_rsp_t         rsp_data_next;
  logic              walk_end;
  logic [LIM_W-1:0]  rows_ext, cols_ext;

  // saturate the grid size to 1..MAX
  assign rows_ext = LIM_W'(cfg.grid_rows);
  assign cols_ext = LIM_W'(cfg.grid_cols);

  always_comb begin
    if (rows_ext == '0) begin
      cfg_last_row = '0;
    end else if (rows_ext > LIM_W'(MAX_ROWS)) begin
      cfg_last_row = RW'(MAX_ROWS - 1);
    end else begin
      cfg_last_row = RW'(rows_ext - LIM_W'(1));
    end
    if (cols_ext == '0) begin
      cfg_last_col = '0;
    end else if (cols_ext > LIM_W'(MAX_COLS)) begin
      cfg_last_col = CW'(MAX_COLS - 1);
    end else begin
      cfg_last_col = CW'(cols_ext - LIM_W'(1));
    end
  end

  // column-major walk: rows inner, columns outer
  assign walk_end = (row == last_row) && (col == last_col);

  always_comb begin
    if (row == last_row) begin
      row_adv  = '0;
      col_adv  = col + CW'(1);
      addr_adv = AW'(col) + AW'(1);
    end else begin
      row_adv  = row + RW'(1);
      col_adv  = col;
      addr_adv = addr + AW'(MAX_COLS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      row       <= '0;
      col       <= '0;
      addr      <= '0;
      last_row  <= '0;
      last_col  <= '0;
      func      <= FUNC_FILL;
      slot      <= '0;
      turn      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      col       <= col_next;
      addr      <= addr_next;
      last_row  <= last_row_next;
      last_col  <= last_col_next;
      func      <= func_next;
      slot      <= slot_next;
      turn      <= turn_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos_row  <= pos_row_next;
    pos_col  <= pos_col_next;
    rsp_data <= rsp_data_next;
  end

  always_comb begin
    state_next     = state;
    row_next       = row;
    col_next       = col;
    addr_next      = addr;
    last_row_next  = last_row;
    last_col_next  = last_col;
    func_next      = func;
    pos_row_next   = pos_row;
    pos_col_next   = pos_col;
    slot_next      = slot;
    turn_next      = turn;
    rsp_valid_next = rsp_valid;
    rsp_data_next  = rsp_data;
    ctl            = '0;
    req_stall      = (state != ST_IDLE);

    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        ctl.wr = 1'b1;
        if (addr == AW'(DEPTH - 1)) begin
          addr_next  = '0;
          state_next = ST_IDLE;
        end else begin
          addr_next = addr + AW'(1);
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          func_next     = req_data.func;
          pos_row_next  = req_data.pos_row;
          pos_col_next  = req_data.pos_col;
          row_next      = '0;
          col_next      = '0;
          addr_next     = '0;
          last_row_next = cfg_last_row;
          last_col_next = cfg_last_col;
          slot_next     = turn;
          ctl.acc_op    = ACC_CLEAR;
          state_next    = (req_data.func == FUNC_FILL) ? ST_FILL : ST_SCAN;
        end
      end
      ST_FILL: begin
        ctl.wr      = 1'b1;
        ctl.wr_fill = 1'b1;
        ctl.acc_op  = ACC_FILL;
        if (walk_end) begin
          state_next = ST_DONE;
        end else begin
          row_next  = row_adv;
          col_next  = col_adv;
          addr_next = addr_adv;
        end
      end
      ST_SCAN: begin
        ctl.rd    = 1'b1;
        ctl.first = (row == '0) && (col == '0);
        if (walk_end) begin
          state_next = ST_DRAIN;
        end else begin
          row_next  = row_adv;
          col_next  = col_adv;
          addr_next = addr_adv;
        end
      end
      ST_DRAIN: begin
        state_next = ST_TAKE;
      end
      ST_TAKE: begin
        ctl.wr      = 1'b1;
        ctl.wr_best = 1'b1;
        ctl.acc_op  = ACC_TAKE;
        state_next  = ST_MOD;
      end
      ST_MOD: begin
        // wrap the turn counter after a drone count change
        if (DRONE_W'(slot) >= cfg.drones) begin
          slot_next = SLOT_W'(DRONE_W'(slot) - cfg.drones);
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next               = 1'b1;
          rsp_data_next.remaining_sum  = total[SUM_OUT_W-1:0];
          rsp_data_next.done_res       = (total == '0);
          if (func == FUNC_FILL) begin
            rsp_data_next.sel_row      = '0;
            rsp_data_next.sel_col      = '0;
            rsp_data_next.sel_priority = '0;
            rsp_data_next.drone_slot   = '0;
            turn_next                  = '0;
          end else begin
            rsp_data_next.sel_row      = POS_W'(best_row);
            rsp_data_next.sel_col      = POS_W'(best_col);
            rsp_data_next.sel_priority = best_prio;
            rsp_data_next.drone_slot   = slot;
            turn_next = ((DRONE_W'(slot) + DRONE_W'(1)) == cfg.drones) ? '0 :
                        slot + SLOT_W'(1);
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `PGNC_ASSERT_NXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  `PGNC_ASSERT_IMP(a_walk_in_grid, clk, rst, state == ST_SCAN, (row <= last_row) && (col <= last_col))
  `PGNC_ASSERT_IMP(a_slot_wrapped, clk, rst, (state == ST_DONE) && (func == FUNC_SELECT), DRONE_W'(slot) < cfg.drones)
  `PGNC_ASSERT_NXT(a_rsp_drains, clk, rst, rsp_valid && !rsp_stall && (state != ST_DONE), !rsp_valid)

endmodule

// ===== hdl/priority_grid_next_cell_unit.sv =====
// Top level of the priority grid next-cell unit: configuration registers and
// the sequencer/compare unit pair. Depends on pgnc_pkg, pgnc_ctrl, pgnc_scan.
//
// Request channel (req_valid/req_stall/req_data): func 0 fills the grid in use
// with fill_priority, func 1 selects the best cell relative to pos_row/pos_col.
// A beat moves when valid is high and stall is low. Response channel
// (rsp_valid/rsp_stall/rsp_data) returns one beat per request.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; write it only while no request is in flight.
// Steps, with R x C the grid in use: a fill writes the R*C cells, a select
// reads them, one cell a cycle through the single read/write port of the
// cell memory; a select then drains the compare unit, clears the chosen cell
// and runs the turn counter's wrap steps (none unless the drone count shrank).
// One request is in the unit at a time; req_stall is high until the result is
// in the response register, which then holds it while rsp_stall is high.
// After rst all MAX_ROWS*MAX_COLS cells of the cell memory (4096 at defaults)
// are cleared, one cell a cycle, with req_stall high.
`timescale 1ns / 1ps
module priority_grid_next_cell_unit import pgnc_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  pgnc_req_t             req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output pgnc_rsp_t             rsp_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [GRID_W-1:0]  grid_rows;
  logic [GRID_W-1:0]  grid_cols;
  logic [CELL_W-1:0]  fill_priority;
  logic [DRONE_W-1:0] num_drones;
  pgnc_cfg_t          cfg;

  pgnc_scan_ctl_t     ctl;
  logic [AW-1:0]      addr;
  logic [RW-1:0]      row, best_row;
  logic [CW-1:0]      col, best_col;
  logic [POS_W-1:0]   pos_row, pos_col;
  logic [CELL_W-1:0]  best_prio;
  logic [TOTAL_W-1:0] total;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows     <= RST_GRID_ROWS;
      grid_cols     <= RST_GRID_COLS;
      fill_priority <= RST_FILL_PRIORITY;
      num_drones    <= RST_NUM_DRONES;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_ROWS:     grid_rows     <= cfg_data[GRID_W-1:0];
        CFG_GRID_COLS:     grid_cols     <= cfg_data[GRID_W-1:0];
        CFG_FILL_PRIORITY: fill_priority <= cfg_data[CELL_W-1:0];
        CFG_NUM_DRONES:    num_drones    <= cfg_data[DRONE_W-1:0];
        default: ;
      endcase
    end
  end

  // drone count saturated to 1..MAX_DRONES
  always_comb begin
    cfg.grid_rows     = grid_rows;
    cfg.grid_cols     = grid_cols;
    cfg.fill_priority = fill_priority;
    if (num_drones == '0) begin
      cfg.drones = DRONE_W'(1);
    end else if (num_drones > DRONE_W'(MAX_DRONES)) begin
      cfg.drones = DRONE_W'(MAX_DRONES);
    end else begin
      cfg.drones = num_drones;
    end
  end

  pgnc_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .ctl       (ctl),
    .addr      (addr),
    .row       (row),
    .col       (col),
    .pos_row   (pos_row),
    .pos_col   (pos_col),
    .best_row  (best_row),
    .best_col  (best_col),
    .best_prio (best_prio),
    .total     (total)
  );

  pgnc_scan #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .addr      (addr),
    .row       (row),
    .col       (col),
    .pos_row   (pos_row),
    .pos_col   (pos_col),
    .fill_prio (cfg.fill_priority),
    .best_row  (best_row),
    .best_col  (best_col),
    .best_prio (best_prio),
    .total     (total)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for priority_grid_next_cell_unit: fill and select requests
// against a cell-grid predictor, under random idling and register settings.
// Depends on pgnc_pkg and the unit's RTL; no files or arguments are read.
`timescale 1ns / 1ps
module tb;
  import pgnc_pkg::*;

  localparam int QUIET_LIMIT = 30000;
  localparam int LONG_HOLD   = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  pgnc_req_t             req_data = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  pgnc_rsp_t             rsp_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  priority_grid_next_cell_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state: register copies, cell grid [row][col], drone turn
  logic [GRID_W-1:0]  rows_reg   = RST_GRID_ROWS;
  logic [GRID_W-1:0]  cols_reg   = RST_GRID_COLS;
  logic [CELL_W-1:0]  fill_reg   = RST_FILL_PRIORITY;
  logic [DRONE_W-1:0] drones_reg = RST_NUM_DRONES;
  logic [CELL_W-1:0]  cell_pri [DEF_MAX_ROWS][DEF_MAX_COLS];
  int                 drone_turn = 0;

  pgnc_req_t reqs_to_send [$];
  pgnc_rsp_t picks_due [$];

  int  n_queued = 0;
  int  n_checked = 0;
  int  n_fills = 0;
  int  n_settings = 0;
  int  bad = 0;
  int  hold_token = 0;
  bit  sender_calm = 1'b0;
  bit  receiver_calm = 1'b0;

  function automatic int grid_span(input int v, input int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic pgnc_rsp_t next_cell(input pgnc_req_t rq);
    pgnc_rsp_t pick;
    int rows, cols, drones, best_p, best_d, d, dr, dc, total, slot, r, c;
    bit have;
    rows   = grid_span(int'(rows_reg), DEF_MAX_ROWS);
    cols   = grid_span(int'(cols_reg), DEF_MAX_COLS);
    drones = grid_span(int'(drones_reg), MAX_DRONES);
    pick   = '0;
    if (rq.func == FUNC_FILL) begin
      for (c = 0; c < cols; c++)
        for (r = 0; r < rows; r++)
          cell_pri[r][c] = fill_reg;
      drone_turn = 0;
    end else begin
      have   = 1'b0;
      best_p = 0;
      best_d = 0;
      for (c = 0; c < cols; c++) begin
        for (r = 0; r < rows; r++) begin
          dr = r - int'(rq.pos_row);
          dc = c - int'(rq.pos_col);
          d  = dr * dr + dc * dc;
          if (!have || int'(cell_pri[r][c]) > best_p ||
              (int'(cell_pri[r][c]) == best_p && d < best_d)) begin
            have          = 1'b1;
            best_p        = int'(cell_pri[r][c]);
            best_d        = d;
            pick.sel_row  = POS_W'(r);
            pick.sel_col  = POS_W'(c);
          end
        end
      end
      pick.sel_priority = CELL_W'(best_p);
      cell_pri[pick.sel_row][pick.sel_col] = '0;
      slot = drone_turn % drones;
      drone_turn = (slot + 1) % drones;
      pick.drone_slot = SLOT_W'(slot);
    end
    total = 0;
    for (c = 0; c < cols; c++)
      for (r = 0; r < rows; r++)
        total += int'(cell_pri[r][c]);
    pick.remaining_sum = SUM_OUT_W'(total);
    pick.done_res      = (total == 0);
    return pick;
  endfunction

  // request driver
  always @(posedge clk) begin : drive_req
    int send_wait;
    if (rst) begin
      req_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (req_valid && !req_stall) begin
        picks_due.insert(picks_due.size(), next_cell(req_data));
        if (req_data.func == FUNC_FILL) n_fills++;
        send_wait = sender_calm ? 0 : $urandom_range(0, 10);
      end
      if (!req_valid || !req_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          req_valid <= 1'b0;
        end else if (reqs_to_send.size() > 0) begin
          req_data  <= reqs_to_send.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_rsp
    pgnc_rsp_t want;
    int take_wait;
    int hold_seen;
    if (rst) begin
      rsp_stall <= 1'b0;
      take_wait = 0;
      hold_seen = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        n_checked++;
        if (picks_due.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("[%0t] extra beat: row %0d col %0d pri %0d sum %0d slot %0d done %0b",
                     $realtime, rsp_data.sel_row, rsp_data.sel_col, rsp_data.sel_priority,
                     rsp_data.remaining_sum, rsp_data.drone_slot, rsp_data.done_res);
        end else begin
          want = picks_due.pop_front();
          if (rsp_data.sel_row !== want.sel_row || rsp_data.sel_col !== want.sel_col ||
              rsp_data.sel_priority !== want.sel_priority ||
              rsp_data.remaining_sum !== want.remaining_sum ||
              rsp_data.drone_slot !== want.drone_slot ||
              rsp_data.done_res !== want.done_res) begin
            bad++;
            if (bad <= 10) begin
              $display("[%0t] mismatch exp: row %0d col %0d pri %0d sum %0d slot %0d done %0b",
                       $realtime, want.sel_row, want.sel_col, want.sel_priority,
                       want.remaining_sum, want.drone_slot, want.done_res);
              $display("[%0t] mismatch got: row %0d col %0d pri %0d sum %0d slot %0d done %0b",
                       $realtime, rsp_data.sel_row, rsp_data.sel_col, rsp_data.sel_priority,
                       rsp_data.remaining_sum, rsp_data.drone_slot, rsp_data.done_res);
            end
          end
        end
        take_wait = receiver_calm ? 0 : $urandom_range(0, 10);
      end else if (take_wait > 0) begin
        take_wait--;
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        take_wait = LONG_HOLD;
      end
      rsp_stall <= (take_wait > 0);
    end
  end

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout after %0d quiet cycles", quiet);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic queue_req(input logic func, input int prow, input int pcol);
    pgnc_req_t rq;
    rq.func    = func;
    rq.pos_row = POS_W'(prow);
    rq.pos_col = POS_W'(pcol);
    reqs_to_send.insert(reqs_to_send.size(), rq);
    n_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (n_checked != n_queued);
  endtask

  task automatic program_regs(input logic [7:0] rows, input logic [7:0] cols,
                              input logic [7:0] fill, input logic [7:0] drones);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    int k;
    idx = '{CFG_GRID_ROWS, CFG_GRID_COLS, CFG_FILL_PRIORITY, CFG_NUM_DRONES};
    val = '{rows, cols, fill, drones};
    for (k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        CFG_GRID_ROWS:     rows_reg   = val[k][GRID_W-1:0];
        CFG_GRID_COLS:     cols_reg   = val[k][GRID_W-1:0];
        CFG_FILL_PRIORITY: fill_reg   = val[k];
        CFG_NUM_DRONES:    drones_reg = val[k][DRONE_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // mostly fill-then-select runs, so small grids drain to empty; split pauses the
  // sender halfway until every result is back
  task automatic run_phase(input logic [7:0] rows, input logic [7:0] cols,
                           input logic [7:0] fill, input logic [7:0] drones,
                           input int n, input bit fill_first, input bit calm,
                           input bit split);
    int eff_r, eff_c, i;
    wait_idle();
    program_regs(rows, cols, fill, drones);
    eff_r = grid_span(int'(rows[6:0]), DEF_MAX_ROWS);
    eff_c = grid_span(int'(cols[6:0]), DEF_MAX_COLS);
    @(negedge clk);
    sender_calm   = calm;
    receiver_calm = calm;
    for (i = 0; i < n; i++) begin
      if (split && i == n / 2) begin
        wait_idle();
        @(negedge clk);
      end
      if ((i == 0 && fill_first) || $urandom_range(0, 11) == 0)
        queue_req(FUNC_FILL, $urandom_range(0, 63), $urandom_range(0, 63));
      else
        queue_req(FUNC_SELECT,
                  $urandom_range(0, 1) ? $urandom_range(0, eff_r - 1) : $urandom_range(0, 63),
                  $urandom_range(0, 1) ? $urandom_range(0, eff_c - 1) : $urandom_range(0, 63));
    end
    if (calm) hold_token++;
  endtask

  initial begin : stimulus
    int r, c;
    for (r = 0; r < DEF_MAX_ROWS; r++)
      for (c = 0; c < DEF_MAX_COLS; c++)
        cell_pri[r][c] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, empty grid first, then fill and distance ties
    queue_req(FUNC_SELECT, 0, 0);
    queue_req(FUNC_SELECT, 63, 63);
    queue_req(FUNC_SELECT, 2, 3);
    queue_req(FUNC_FILL, 63, 0);
    queue_req(FUNC_SELECT, 2, 2);
    queue_req(FUNC_SELECT, 2, 2);
    queue_req(FUNC_SELECT, 0, 63);
    queue_req(FUNC_SELECT, 63, 0);
    queue_req(FUNC_FILL, 0, 0);
    queue_req(FUNC_SELECT, 63, 63);
    wait_idle();

    // four drones, full-scale fill priority
    program_regs(8'd5, 8'd5, 8'd255, 8'd4);
    @(negedge clk);
    queue_req(FUNC_FILL, 21, 42);
    queue_req(FUNC_SELECT, 42, 21);
    queue_req(FUNC_SELECT, 0, 0);
    queue_req(FUNC_SELECT, 63, 63);
    queue_req(FUNC_SELECT, 4, 4);
    queue_req(FUNC_SELECT, 0, 4);
    queue_req(FUNC_SELECT, 4, 0);
    queue_req(FUNC_SELECT, 2, 2);

    run_phase(8'd0,   8'd1,  8'd255, 8'd0,  6,  1'b1, 1'b0, 1'b0);
    run_phase(8'd1,   8'd64, 8'd0,   8'd16, 8,  1'b1, 1'b0, 1'b0);
    run_phase(8'd3,   8'd4,  8'd255, 8'd3,  16, 1'b1, 1'b0, 1'b0);
    run_phase(8'd4,   8'd3,  8'd200, 8'd31, 16, 1'b1, 1'b0, 1'b0);
    run_phase(8'd127, 8'd2,  8'd17,  8'd5,  12, 1'b1, 1'b0, 1'b0);
    run_phase(8'd2,   8'd2,  8'd9,   8'd2,  10, 1'b1, 1'b1, 1'b0);
    run_phase(8'd64,  8'd64, 8'd255, 8'd16, 4,  1'b1, 1'b0, 1'b0);
    run_phase(8'd6,   8'd5,  8'd128, 8'd2,  16, 1'b0, 1'b0, 1'b0);
    run_phase(8'd8,   8'd8,  8'($urandom_range(0, 255)), 8'($urandom_range(1, 16)),
              25, 1'b1, 1'b0, 1'b1);
    run_phase(8'd5,   8'd7,  8'($urandom_range(0, 255)), 8'd7, 25, 1'b1, 1'b0, 1'b0);

    wait_idle();
    repeat (20) @(posedge clk);
    bad += picks_due.size();
    $display("Covered %0d requests (%0d fills), %0d register settings, grids 1x1 to 64x64.",
             n_queued, n_fills, n_settings);
    $display("Checked %0d result beats, %0d failures.", n_checked, bad);
    if (bad == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
